// ===== rtl/edm_pkg.sv =====
// ----------------------------------------------------------------------------
// edm_pkg
// Shared types and constants for the signed 64-bit Euclidean divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package edm_pkg;

  localparam int unsigned Width = 64;
  localparam int unsigned RemWidth = Width - 1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StDivZero  = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [Width-1:0] dividend;
    logic signed [Width-1:0] divisor;
  } edm_req_t;

  typedef struct packed {
    logic signed [Width-1:0] quotient;
    logic [RemWidth-1:0]     remainder;
    status_e                 status;
  } edm_rsp_t;

  // Working state that travels down the divider chain.
  typedef struct packed {
    logic [Width-1:0] rem;
    logic [Width-1:0] aq;
    logic [Width-1:0] mb;
    logic             a_neg;
    logic             b_neg;
    status_e          status;
  } edm_stage_t;

endpackage

`default_nettype wire

// ===== rtl/edm_prep.sv =====
// ----------------------------------------------------------------------------
// edm_prep
// Input stage: flags special cases and takes operand magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module edm_prep import edm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       up_valid_i,
  output logic            up_ready_o,
  input  wire edm_req_t   up_data_i,
  output logic            dn_valid_o,
  input  wire logic       dn_ready_i,
  output edm_stage_t      dn_data_o
);

  logic       valid_q;
  edm_stage_t data_q, data_d;
  logic       a_neg, b_neg;

  always_comb begin
    a_neg = up_data_i.dividend[Width-1];
    b_neg = up_data_i.divisor[Width-1];
    data_d.rem   = '0;
    data_d.aq    = a_neg ? (~up_data_i.dividend + 1'b1) : up_data_i.dividend;
    data_d.mb    = b_neg ? (~up_data_i.divisor + 1'b1) : up_data_i.divisor;
    data_d.a_neg = a_neg;
    data_d.b_neg = b_neg;
    if (up_data_i.divisor == '0) begin
      data_d.status = StDivZero;
    end else if (up_data_i.dividend == {1'b1, {(Width-1){1'b0}}} &&
                 up_data_i.divisor == {Width{1'b1}}) begin
      data_d.status = StOverflow;
    end else begin
      data_d.status = StOk;
    end
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/edm_cell.sv =====
// ----------------------------------------------------------------------------
// edm_cell
// One restoring divide step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module edm_cell import edm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       up_valid_i,
  output logic            up_ready_o,
  input  wire edm_stage_t up_data_i,
  output logic            dn_valid_o,
  input  wire logic       dn_ready_i,
  output edm_stage_t      dn_data_o
);

  logic       valid_q;
  edm_stage_t data_q, data_d;
  logic [Width:0] shifted;
  logic [Width:0] diff;
  logic           ge;

  always_comb begin
    shifted = {up_data_i.rem, up_data_i.aq[Width-1]};
    diff    = shifted - {1'b0, up_data_i.mb};
    ge      = !diff[Width];
    data_d      = up_data_i;
    data_d.rem  = ge ? diff[Width-1:0] : shifted[Width-1:0];
    data_d.aq   = {up_data_i.aq[Width-2:0], ge};
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/edm_post.sv =====
// ----------------------------------------------------------------------------
// edm_post
// Output stage: applies signs, the Euclidean fix-up and the status zeroing.
// ----------------------------------------------------------------------------
`default_nettype none

module edm_post import edm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       up_valid_i,
  output logic            up_ready_o,
  input  wire edm_stage_t up_data_i,
  output logic            dn_valid_o,
  input  wire logic       dn_ready_i,
  output edm_rsp_t        dn_data_o
);

  logic     valid_q;
  edm_rsp_t data_q, data_d;
  logic     fix;
  logic     differ;
  logic [Width-1:0] uq;
  logic [Width-1:0] q;
  logic [Width-1:0] r;

  always_comb begin
    uq     = up_data_i.aq;
    fix    = up_data_i.a_neg && (up_data_i.rem != '0);
    differ = up_data_i.a_neg != up_data_i.b_neg;
    // With differing signs, the fixed quotient -uq - 1 equals ~uq.
    case ({differ, fix})
      2'b11:   q = ~uq;
      2'b10:   q = ~uq + 1'b1;
      2'b01:   q = uq + 1'b1;
      default: q = uq;
    endcase
    r = fix ? (up_data_i.mb - up_data_i.rem) : up_data_i.rem;
    data_d.status = up_data_i.status;
    if (up_data_i.status == StOk) begin
      data_d.quotient  = q;
      data_d.remainder = r[RemWidth-1:0];
    end else begin
      data_d.quotient  = '0;
      data_d.remainder = '0;
    end
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/euclidean_divmod_int64_unit.sv =====
// Stages: one input stage, 64 divide cells and one output stage.
// Throughput: one request per cycle while the output side does not stall;
// every stage has its own register and ready, so bubbles collapse and a
// request is taken while a result waits.
// Reset: asynchronous, active low; clears all valid bits, the pipe is empty.
// ----------------------------------------------------------------------------
// euclidean_divmod_int64_unit
// Pipelined signed 64-bit Euclidean divide with non-negative remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_divmod_int64_unit import edm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire edm_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output edm_rsp_t      out_data_o
);

  logic       valid [Width+1];
  logic       ready [Width+1];
  edm_stage_t stage [Width+1];

  edm_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready_o),
    .up_data_i  (in_data_i),
    .dn_valid_o (valid[0]),
    .dn_ready_i (ready[0]),
    .dn_data_o  (stage[0])
  );

  for (genvar k = 0; k < Width; k++) begin : g_cell
    edm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (valid[k]),
      .up_ready_o (ready[k]),
      .up_data_i  (stage[k]),
      .dn_valid_o (valid[k+1]),
      .dn_ready_i (ready[k+1]),
      .dn_data_o  (stage[k+1])
    );
  end

  edm_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (valid[Width]),
    .up_ready_o (ready[Width]),
    .up_data_i  (stage[Width]),
    .dn_valid_o (out_valid_o),
    .dn_ready_i (out_ready_i),
    .dn_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |->
      out_data_o.quotient == '0 && out_data_o.remainder == '0)
    else $error("Error result carries a nonzero quotient or remainder.");

  a_ok_nonzero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[0] && stage[0].status == StOk |-> stage[0].mb != '0)
    else $error("Request marked ok with a zero divisor magnitude.");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[Width] && stage[Width].status == StOk |-> stage[Width].rem < stage[Width].mb)
    else $error("Unsigned remainder is not below the divisor magnitude.");
`endif

endmodule

`default_nettype wire
